### sv/cpualu_pkg.sv
// Shared types and constants for the eight-bit CPU ALU.
`default_nettype none
package cpualu_pkg;

	localparam int OP_W        = 4;
	localparam int ACC_W       = 8;
	localparam int WORD_W      = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 4'd0,
		OP_ADC   = 4'd1,
		OP_SUB   = 4'd2,
		OP_SBC   = 4'd3,
		OP_AND   = 4'd4,
		OP_OR    = 4'd5,
		OP_XOR   = 4'd6,
		OP_CP    = 4'd7,
		OP_ADD16 = 4'd8,
		OP_ADDSP = 4'd9,
		OP_INC16 = 4'd10,
		OP_DEC16 = 4'd11
	} op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage
`default_nettype wire

### sv/cpualu_core.sv
// Combinational ALU: one operation on the accumulator, flags and a 16-bit word.
`default_nettype none
module cpualu_core
	import cpualu_pkg::*;
(
	input  logic [OP_W-1:0]   operation,
	input  logic [WORD_W-1:0] operand,
	input  logic              carry_in,
	input  logic [WORD_W-1:0] word_in,
	input  logic [ACC_W-1:0]  acc_in,
	input  flags_t            flags_in,
	output logic [ACC_W-1:0]  acc_out,
	output flags_t            flags_out,
	output logic [WORD_W-1:0] word_out
);

	op_t              op;
	logic [ACC_W-1:0] lo;
	logic             cin;
	logic [ACC_W:0]   sum9;
	logic [4:0]       sum5;
	logic [ACC_W:0]   diff9;
	logic [4:0]       diff5;
	logic [WORD_W:0]  sum17;
	logic [12:0]      sum13;
	logic [ACC_W:0]   sp9;
	logic [4:0]       sp5;
	logic [ACC_W-1:0] logic_res;

	assign op  = op_t'(operation);
	assign lo  = operand[ACC_W-1:0];
	// Only adc and sbc take the incoming carry; it is folded into the full-width sums.
	assign cin = ((op == OP_ADC) || (op == OP_SBC)) ? carry_in : 1'b0;

	assign sum9  = {1'b0, acc_in} + {1'b0, lo} + {{ACC_W{1'b0}}, cin};
	assign sum5  = {1'b0, acc_in[3:0]} + {1'b0, lo[3:0]} + {4'd0, cin};
	assign diff9 = {1'b0, acc_in} - {1'b0, lo} - {{ACC_W{1'b0}}, cin};
	assign diff5 = {1'b0, acc_in[3:0]} - {1'b0, lo[3:0]} - {4'd0, cin};
	assign sum17 = {1'b0, word_in} + {1'b0, operand};
	assign sum13 = {1'b0, word_in[11:0]} + {1'b0, operand[11:0]};
	assign sp9   = {1'b0, word_in[7:0]} + {1'b0, lo};
	assign sp5   = {1'b0, word_in[3:0]} + {1'b0, lo[3:0]};

	always_comb begin
		acc_out   = acc_in;
		flags_out = flags_in;
		word_out  = word_in;
		logic_res = acc_in & lo;
		unique case (op)
			OP_ADD, OP_ADC: begin
				acc_out   = sum9[ACC_W-1:0];
				flags_out = '{z: (sum9[ACC_W-1:0] == '0), n: 1'b0, h: sum5[4], c: sum9[ACC_W]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (op != OP_CP) begin
					acc_out = diff9[ACC_W-1:0];
				end
				flags_out = '{z: (diff9[ACC_W-1:0] == '0), n: 1'b1, h: diff5[4],
					c: diff9[ACC_W]};
			end
			OP_AND, OP_OR, OP_XOR: begin
				case (op)
					OP_OR:   logic_res = acc_in | lo;
					OP_XOR:  logic_res = acc_in ^ lo;
					default: logic_res = acc_in & lo;
				endcase
				acc_out   = logic_res;
				flags_out = '{z: (logic_res == '0), n: 1'b0, h: (op == OP_AND), c: 1'b0};
			end
			OP_ADD16: begin
				word_out  = sum17[WORD_W-1:0];
				flags_out = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[WORD_W]};
			end
			OP_ADDSP: begin
				// The word add sign-extends the offset; the flags use the unsigned low byte.
				word_out  = word_in + {{(WORD_W-ACC_W){lo[ACC_W-1]}}, lo};
				flags_out = '{z: 1'b0, n: 1'b0, h: sp5[4], c: sp9[ACC_W]};
			end
			OP_INC16: word_out = word_in + 16'd1;
			OP_DEC16: word_out = word_in - 16'd1;
			default: begin
				acc_out = acc_in;
			end
		endcase
	end

endmodule
`default_nettype wire

### sv/eight_bit_cpu_alu_flags_top.sv
// Top level of the eight-bit CPU ALU with accumulator and flag state.
`default_nettype none
// Takes one operation request per clock while the result side does not stall, and returns one
// result per request, in order. A request passes an input register, then the ALU logic, which
// reads and updates the accumulator and flags in the same cycle, and lands in a result register.
// The result register is the only buffer on the output side, so a stalled consumer holds the
// input register and then the input side after one more request.
module eight_bit_cpu_alu_flags_top
	import cpualu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// operand [15:0], carry_in [16], word_in [32:17], zero fill [39:33]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// operation [3:0]
	input  logic [OP_W-1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// acc_out [7:0], zero_flag [8], subtract_flag [9], half_carry_flag [10],
	// carry_flag [11], word_out [27:12], zero fill [31:28]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [WORD_W-1:0] operand_s1;
	logic              cin_s1;
	logic [WORD_W-1:0] word_s1;

	logic              valid_s2;
	logic [ACC_W-1:0]  acc_s2;
	flags_t            flags_s2;
	logic [WORD_W-1:0] word_s2;

	logic [ACC_W-1:0]  acc_q;
	flags_t            flags_q;

	logic [ACC_W-1:0]  acc_nx;
	flags_t            flags_nx;
	logic [WORD_W-1:0] word_nx;
	logic              out_free;
	logic              commit;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign commit        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || commit;

	cpualu_core u_core (
		.operation (op_s1),
		.operand   (operand_s1),
		.carry_in  (cin_s1),
		.word_in   (word_s1),
		.acc_in    (acc_q),
		.flags_in  (flags_q),
		.acc_out   (acc_nx),
		.flags_out (flags_nx),
		.word_out  (word_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			flags_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			// Architectural state moves only when a request hands its result over.
			if (commit) begin
				acc_q   <= acc_nx;
				flags_q <= flags_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= s_axis_tuser;
			operand_s1 <= s_axis_tdata[15:0];
			cin_s1     <= s_axis_tdata[16];
			word_s1    <= s_axis_tdata[32:17];
		end
		if (commit) begin
			acc_s2   <= acc_nx;
			flags_s2 <= flags_nx;
			word_s2  <= word_nx;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, word_s2, flags_s2.c, flags_s2.h, flags_s2.n, flags_s2.z,
		acc_s2};

`ifndef SYNTHESIS
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> ($stable(acc_q) && $stable(flags_q)))
		else $error("accumulator or flags changed without a committed request");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("committed request did not produce a result");

	a_result_acc: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (acc_s2 == acc_q) && (flags_s2 == flags_q))
		else $error("result disagrees with updated state");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && valid_s1) |-> !s_axis_tready)
		else $error("input accepted while both stages are stalled");
`endif

endmodule
`default_nettype wire

### test/tb_eight_bit_cpu_alu_flags_top.sv
// Testbench for the eight-bit CPU ALU top level: random and directed requests, checked in order.
`default_nettype none

class alu_flag_tracker;

	typedef struct {
		logic [7:0]  acc;
		logic        z;
		logic        n;
		logic        h;
		logic        c;
		logic [15:0] word;
	} alu_result_t;

	logic [7:0]            acc;
	cpualu_pkg::flags_t    flags;
	alu_result_t           pending_results[$];
	int                    mismatches;

	function new();
		acc        = 8'd0;
		flags      = '0;
		mismatches = 0;
	endfunction

	// Executes one operation on the tracked accumulator and flags.
	function alu_result_t execute(logic [3:0] op, logic [15:0] operand, logic carry,
			logic [15:0] word);
		alu_result_t r;
		int a;
		int v;
		int b;
		int total;
		logic [15:0] wout;
		a    = int'(acc);
		v    = int'(operand[7:0]);
		wout = word;
		case (op)
			cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
				b     = (op == cpualu_pkg::OP_ADC) ? int'(carry) : 0;
				total = a + v + b;
				acc   = total[7:0];
				flags = {acc == 8'd0, 1'b0, ((a & 15) + (v & 15) + b) > 15, total > 255};
			end
			cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP: begin
				b     = (op == cpualu_pkg::OP_SBC) ? int'(carry) : 0;
				total = a - v - b;
				flags = {total[7:0] == 8'd0, 1'b1, (a & 15) < ((v & 15) + b), a < (v + b)};
				if (op != cpualu_pkg::OP_CP) begin
					acc = total[7:0];
				end
			end
			cpualu_pkg::OP_AND: begin
				acc   = acc & operand[7:0];
				flags = {acc == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			cpualu_pkg::OP_OR: begin
				acc   = acc | operand[7:0];
				flags = {acc == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			cpualu_pkg::OP_XOR: begin
				acc   = acc ^ operand[7:0];
				flags = {acc == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			cpualu_pkg::OP_ADD16: begin
				total = int'(word) + int'(operand);
				flags = {flags.z, 1'b0,
					(int'(word[11:0]) + int'(operand[11:0])) > 'hfff, total > 'hffff};
				wout  = total[15:0];
			end
			cpualu_pkg::OP_ADDSP: begin
				// The carries come from the unsigned low byte even though the add is signed.
				flags = {1'b0, 1'b0, (int'(word[3:0]) + (v & 15)) > 15,
					(int'(word[7:0]) + v) > 255};
				wout  = word + {{8{operand[7]}}, operand[7:0]};
			end
			cpualu_pkg::OP_INC16: wout = word + 16'd1;
			cpualu_pkg::OP_DEC16: wout = word - 16'd1;
			default: ;
		endcase
		r.acc  = acc;
		r.z    = flags.z;
		r.n    = flags.n;
		r.h    = flags.h;
		r.c    = flags.c;
		r.word = wout;
		return r;
	endfunction

	function void note_request(logic [3:0] op, logic [15:0] operand, logic carry,
			logic [15:0] word);
		pending_results.push_back(execute(op, operand, carry, word));
	endfunction

	function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
		if (expected !== actual) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected,
				actual);
		end
	endfunction

	function void check_result(logic [cpualu_pkg::OUT_TDATA_W-1:0] data);
		alu_result_t e;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result: expected none, actual %h", $time, data);
			return;
		end
		e = pending_results.pop_front();
		compare_field("acc_out", 16'(e.acc), 16'(data[7:0]));
		compare_field("zero_flag", 16'(e.z), 16'(data[8]));
		compare_field("subtract_flag", 16'(e.n), 16'(data[9]));
		compare_field("half_carry_flag", 16'(e.h), 16'(data[10]));
		compare_field("carry_flag", 16'(e.c), 16'(data[11]));
		compare_field("word_out", e.word, data[27:12]);
	endfunction

endclass

module tb_eight_bit_cpu_alu_flags_top;
	import cpualu_pkg::*;

	localparam int RANDOM_REQUESTS = 1250;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_AT         = 300;
	localparam int HOLD_CYCLES     = 60;
	localparam int DRAIN_AT        = 900;
	localparam int STEADY_FROM     = 500;
	localparam int STEADY_TO       = 700;
	localparam int IDLE_PERCENT    = 20;
	localparam int UNUSED_OP_LO    = int'(OP_DEC16) + 1;
	localparam int UNUSED_OP_HI    = (1 << OP_W) - 1;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [OP_W-1:0]        s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	alu_flag_tracker tracker;
	int              accepted_count;
	int              cycle_count;
	bit              held_off;
	int              hold_left;
	logic            steady;

	eight_bit_cpu_alu_flags_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	assign steady = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("eight_bit_cpu_alu_flags_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_result(m_axis_tdata);
		end
	end

	// Result side: random stalls, one long hold-off, and a stretch with no stalls.
	initial begin
		m_axis_tready <= 1'b0;
		held_off = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (!held_off && accepted_count >= HOLD_AT) begin
				held_off = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	task automatic send_request(logic [3:0] op, logic [15:0] operand, logic carry,
			logic [15:0] word);
		if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, word, carry, operand};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(op, operand, carry, word);
		accepted_count++;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h00ff;
			3: return 16'h0fff;
			4: return 16'h0080 | 16'($urandom_range(0, 127));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [3:0] pick_operation();
		if ($urandom_range(0, 99) < 5) begin
			return 4'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
		end
		return 4'($urandom_range(int'(OP_ADD), int'(OP_DEC16)));
	endfunction

	initial begin
		tracker = new();
		accepted_count = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= '0;
		s_axis_tdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: flag corners of every operation, folded carries and the signed SP add.
		send_request(OP_AND, 16'hff00, 1'b1, 16'h1234);
		send_request(OP_OR, 16'h00ff, 1'b0, 16'hffff);
		send_request(OP_ADD, 16'h0001, 1'b1, 16'h0000);
		send_request(OP_ADC, 16'h00ff, 1'b1, 16'h5555);
		send_request(OP_ADC, 16'hff0f, 1'b1, 16'haaaa);
		send_request(OP_SUB, 16'h0001, 1'b1, 16'h0000);
		send_request(OP_SBC, 16'h00ff, 1'b1, 16'hffff);
		send_request(OP_SBC, 16'h0000, 1'b1, 16'h0001);
		send_request(OP_CP, 16'h00ff, 1'b0, 16'h8000);
		send_request(OP_XOR, 16'hffff, 1'b0, 16'h7fff);
		send_request(OP_XOR, 16'h0000, 1'b1, 16'h0000);
		send_request(OP_ADD16, 16'hffff, 1'b0, 16'h0001);
		send_request(OP_ADD16, 16'h0fff, 1'b1, 16'h0001);
		send_request(OP_ADD16, 16'h0000, 1'b0, 16'h0000);
		send_request(OP_ADDSP, 16'h0080, 1'b0, 16'h0000);
		send_request(OP_ADDSP, 16'hff0f, 1'b0, 16'h00f1);
		send_request(OP_ADDSP, 16'h00ff, 1'b1, 16'hffff);
		send_request(OP_ADDSP, 16'h007f, 1'b0, 16'h7fff);
		send_request(OP_INC16, 16'hffff, 1'b1, 16'hffff);
		send_request(OP_DEC16, 16'h0000, 1'b0, 16'h0000);
		send_request(4'(UNUSED_OP_LO), 16'hffff, 1'b1, 16'hffff);
		send_request(4'(UNUSED_OP_HI), 16'h0000, 1'b0, 16'h1357);
		send_request(OP_CP, 16'h0000, 1'b1, 16'h0000);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (accepted_count == DRAIN_AT) begin
				s_axis_tvalid <= 1'b0;
				while (tracker.pending_results.size() != 0) @(posedge clk);
			end
			send_request(pick_operation(), pick_value(), 1'($urandom()), pick_value());
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("eight_bit_cpu_alu_flags_top test passed");
		end else begin
			$display("eight_bit_cpu_alu_flags_top test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
